### design/pcgu_pkg.sv
package pcgu_pkg;

  localparam int unsigned StateW = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned StreamW = 63;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [StateW-1:0] LcgMult = 64'd6364136223846793005;
  localparam logic [HalfW-1:0]  LcgMultLo = LcgMult[HalfW-1:0];
  localparam logic [HalfW-1:0]  LcgMultHi = LcgMult[StateW-1:HalfW];

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_SEED   = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_STREAM = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_LOWER  = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_UPPER  = 8'd3;

  localparam logic [HalfW-1:0] UpperReset = 32'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_UPD,
    ST_PERM,
    ST_SCALE,
    ST_EMIT
  } state_t;

  // Operand pair for the shared 32x32 multiplier
  typedef enum logic [1:0] {
    MS_LL,
    MS_HL,
    MS_LH,
    MS_SCALE
  } mul_sel_t;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     upd;
    logic     perm;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic bad_range;
    logic out_free;
  } stat_t;

  // XSH-RR output permutation
  function automatic logic [HalfW-1:0] permute(input logic [StateW-1:0] s);
    logic [StateW-1:0]  mix;
    logic [HalfW-1:0]   xs;
    logic [4:0]         rot;
    logic [2*HalfW-1:0] dbl;
    mix = (s >> 18) ^ s;
    xs  = mix[58:27];
    rot = s[63:59];
    dbl = {xs, xs} >> rot;
    return dbl[HalfW-1:0];
  endfunction

endpackage

### design/pcg32_uniform_range_generator.sv
// Channel | Direction | Signals                           | Transaction
// in      | slave     | in_tvalid/in_tready/in_tdata      | one request, restart flag
// out     | master    | out_tvalid/out_tready/out_tdata,  | one sample, raw word,
//         |           | out_tuser                         | range error flag
// cfg     | slave     | cfg_valid/cfg_ready/cfg_index,    | one register write
//         |           | cfg_data                          |
//
// A request holds the block from acceptance until its result is loaded into
// the output register. The 64-bit state update runs as three 32x32 partial
// products through the one shared multiplier, then permute, then the scaling
// multiply. An empty or inverted range skips the arithmetic and goes from the
// idle state straight to the emit state.
// Reset is synchronous and active low; it restores the register defaults and
// clears the seeded flag, so the first request reloads the state from the seed.
// A stalled output holds the result; the next request is taken while it waits
// and then holds in its last cycle, with in_tready low, until the output frees.
module pcg32_uniform_range_generator
  import pcgu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // in_tdata: [0] restart, [7:1] zero
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  // out_tdata: [31:0] sample_value, [63:32] raw_word
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [63:0]        out_tdata,
  // out_tuser: [0] range_error
  output logic [0:0]         out_tuser,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [StateW-1:0]  cfg_data
);

  cmd_t             ctl_cmd;
  stat_t            dp_stat;
  logic [HalfW-1:0] sample;
  logic [HalfW-1:0] raw;
  logic             err;

  // register writes are always taken; software must write only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  pcgu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  pcgu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .restart    (in_tdata[0]),
    .cmd        (ctl_cmd),
    .stat       (dp_stat),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_sample (sample),
    .out_raw    (raw),
    .out_err    (err)
  );

  assign out_tdata    = {raw, sample};
  assign out_tuser[0] = err;

`ifndef ASSERT_OFF
  // one request in flight: acceptance drops ready on the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

  // a result is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.emit |-> dp_stat.out_free)
    else $error("output register overwritten");

  // an error result carries zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 64'd0)
    else $error("range error result with nonzero data");
`endif

endmodule

### design/pcgu_ctrl.sv
module pcgu_ctrl
  import pcgu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MS_LL;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.bad_range ? ST_EMIT : ST_MUL0;
        end
      end
      ST_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_LL;
        state_nxt   = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_HL;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_LH;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_PERM;
      end
      ST_PERM: begin
        cmd.perm  = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_SCALE;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### design/pcgu_dp.sv
module pcgu_dp
  import pcgu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [StateW-1:0]  cfg_wdata,
  input  logic               restart,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [HalfW-1:0]   out_sample,
  output logic [HalfW-1:0]   out_raw,
  output logic               out_err
);

  logic [StateW-1:0]  seed_r;
  logic [StreamW-1:0] stream_r;
  logic [HalfW-1:0]   lower_r;
  logic [HalfW-1:0]   upper_r;

  logic [StateW-1:0]  lcg_r;
  logic               seeded_r;
  logic [StateW-1:0]  acc_r;
  logic [StateW-1:0]  mul_r;
  logic [HalfW-1:0]   raw_r;
  logic [HalfW-1:0]   span_r;
  logic               err_r;
  logic               empty_r;

  logic               out_valid_r;
  logic [HalfW-1:0]   sample_r;
  logic [HalfW-1:0]   raw_out_r;
  logic               err_out_r;

  logic [StateW-1:0]  inc;
  logic signed [HalfW-1:0] lo_s;
  logic signed [HalfW-1:0] hi_s;
  logic [HalfW-1:0]   mul_a;
  logic [HalfW-1:0]   mul_b;
  logic [HalfW-1:0]   acc_hi_sum;

  assign inc  = {stream_r, 1'b1};
  assign lo_s = lower_r;
  assign hi_s = upper_r;

  assign stat.bad_range = (lo_s >= hi_s);
  assign stat.out_free  = !out_valid_r || out_ready;

  always_comb begin
    unique case (cmd.mul_sel)
      MS_LL:    begin mul_a = lcg_r[HalfW-1:0];      mul_b = LcgMultLo; end
      MS_HL:    begin mul_a = lcg_r[StateW-1:HalfW]; mul_b = LcgMultLo; end
      MS_LH:    begin mul_a = lcg_r[HalfW-1:0];      mul_b = LcgMultHi; end
      MS_SCALE: begin mul_a = raw_r;                 mul_b = span_r;    end
      default:  begin mul_a = '0;                    mul_b = '0;        end
    endcase
  end

  assign acc_hi_sum = acc_r[StateW-1:HalfW] + mul_r[HalfW-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= '0;
      stream_r <= '0;
      lower_r  <= '0;
      upper_r  <= UpperReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SEED:   seed_r   <= cfg_wdata;
        REG_STREAM: stream_r <= cfg_wdata[StreamW-1:0];
        REG_LOWER:  lower_r  <= cfg_wdata[HalfW-1:0];
        REG_UPPER:  upper_r  <= cfg_wdata[HalfW-1:0];
        default: ;
      endcase
    end
  end

  // generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_r    <= '0;
      seeded_r <= 1'b0;
    end else if (cmd.accept && (restart || !seeded_r)) begin
      lcg_r    <= seed_r + inc;
      seeded_r <= 1'b1;
    end else if (cmd.upd) begin
      lcg_r <= {acc_hi_sum, acc_r[HalfW-1:0]} + inc;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      err_r   <= (lo_s > hi_s);
      empty_r <= (lo_s == hi_s);
      span_r  <= upper_r - lower_r;
    end
    if (cmd.mul_en) begin
      mul_r <= StateW'(mul_a) * StateW'(mul_b);
    end
    if (cmd.acc_load) begin
      acc_r <= mul_r;
    end else if (cmd.acc_add) begin
      acc_r <= {acc_hi_sum, acc_r[HalfW-1:0]};
    end
    if (cmd.perm) begin
      raw_r <= permute(lcg_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      priority if (err_r) begin
        sample_r  <= '0;
        raw_out_r <= '0;
        err_out_r <= 1'b1;
      end else if (empty_r) begin
        sample_r  <= lower_r;
        raw_out_r <= '0;
        err_out_r <= 1'b0;
      end else begin
        sample_r  <= lower_r + mul_r[StateW-1:HalfW];
        raw_out_r <= raw_r;
        err_out_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;
  assign out_raw    = raw_out_r;
  assign out_err    = err_out_r;

endmodule
